/* sv/hsbi_pkg.sv */
// Package for the hash set bucket insert unit: sizes, result codes and the
// reciprocal used for the bucket index. No dependencies.
`default_nettype none

package hsbi_pkg;

   localparam int BUCKETS      = 10;
   localparam int BUCKET_DEPTH = 4;
   localparam int VALUE_WIDTH  = 16;

   localparam int SLOTS        = BUCKETS * BUCKET_DEPTH;
   localparam int SLOT_WIDTH   = $clog2(SLOTS);
   localparam int FILL_WIDTH   = $clog2(BUCKET_DEPTH + 1);

   // Port widths are fixed
   localparam int VALUE_PORT_WIDTH = 16;
   localparam int KIND_WIDTH       = 2;
   localparam int STATUS_WIDTH     = 2;
   localparam int BUCKET_WIDTH     = 4;

   // floor(2^VALUE_WIDTH / BUCKETS); quotient estimate is low by at most one
   localparam longint unsigned RECIP_FULL = (64'd1 << VALUE_WIDTH) / BUCKETS;
   localparam logic [VALUE_WIDTH-1:0] RECIP = VALUE_WIDTH'(RECIP_FULL);

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_DUMP   = 1'b1;

   localparam logic [KIND_WIDTH-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_EMPTY  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ENTRY  = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_ADDED   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PRESENT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

/* sv/hsbi_if.sv */
// Request and response channel interfaces of the hash set bucket insert unit.
// Depends on hsbi_pkg.
`default_nettype none

interface hsbi_req_if import hsbi_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [VALUE_PORT_WIDTH-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

interface hsbi_rsp_if import hsbi_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [KIND_WIDTH-1:0]       kind;
   logic [STATUS_WIDTH-1:0]     status;
   logic [BUCKET_WIDTH-1:0]     bucket;
   logic [VALUE_PORT_WIDTH-1:0] entry_value;
   logic                        last;

   modport source (output valid, kind, status, bucket, entry_value, last, input ready);
   modport sink   (input valid, kind, status, bucket, entry_value, last, output ready);
endinterface

`default_nettype wire

/* sv/hsbi_bucket_mod.sv */
// Bucket index unit: value mod BUCKETS by reciprocal multiply and one
// correction step; start is registered in stage_ff and then done_ff. Depends on hsbi_pkg.
`default_nettype none

module hsbi_bucket_mod import hsbi_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [VALUE_WIDTH-1:0]  value,
   output logic                         done,
   output logic [BUCKET_WIDTH-1:0]      bucket
);

   logic                        stage_ff, stage_in;
   logic [2*VALUE_WIDTH-1:0]    prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0]      val_ff, val_in;
   logic                        done_ff, done_in;
   logic [BUCKET_WIDTH-1:0]     bucket_ff, bucket_in;

   logic [VALUE_WIDTH-1:0]      quot;
   logic [VALUE_WIDTH-1:0]      quot_mul;
   logic [VALUE_WIDTH-1:0]      rem;

   always_comb begin
      stage_in = start;
      prod_in  = (2*VALUE_WIDTH)'(value) * (2*VALUE_WIDTH)'(RECIP);
      val_in   = value;

      quot     = prod_ff[2*VALUE_WIDTH-1:VALUE_WIDTH];
      quot_mul = VALUE_WIDTH'(quot * VALUE_WIDTH'(BUCKETS));
      rem      = val_ff - quot_mul;
      // estimate may be one short: remainder is below twice BUCKETS
      if (rem >= VALUE_WIDTH'(BUCKETS)) begin
         rem = rem - VALUE_WIDTH'(BUCKETS);
      end
      done_in   = stage_ff;
      bucket_in = BUCKET_WIDTH'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      val_ff    <= val_in;
      bucket_ff <= bucket_in;
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

`default_nettype wire

/* sv/hash_set_bucket_insert_unit.sv */
// Hash set bucket insert unit. Insert: after the bucket index, the entries of the bucket
// (0..BUCKET_DEPTH) are read and compared in turn until a match ends the scan;
// one comparator and one read port of the entry store are stepped over the bucket.
// Dump: an empty response per empty bucket, a read and a response per stored entry.
// One request at a time: the next is accepted once the last result is loaded.
// Synchronous reset clears bucket fill counts; the entry store is not cleared.
`default_nettype none

module hash_set_bucket_insert_unit import hsbi_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   hsbi_req_if.sink    req_chan,
   hsbi_rsp_if.source  rsp_chan
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_DRD  = 3'd5;
   localparam logic [2:0] S_DOUT = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [VALUE_WIDTH-1:0]      value_ff, value_in;
   logic [BUCKET_WIDTH-1:0]     bucket_ff, bucket_in;
   logic [FILL_WIDTH-1:0]       idx_ff, idx_in;
   logic [STATUS_WIDTH-1:0]     status_ff, status_in;
   logic [FILL_WIDTH-1:0]       fill_ff [BUCKETS];
   logic [FILL_WIDTH-1:0]       fill_in [BUCKETS];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KIND_WIDTH-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff, rsp_status_in;
   logic [BUCKET_WIDTH-1:0]     rsp_bucket_ff, rsp_bucket_in;
   logic [VALUE_PORT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0]      entry_mem [SLOTS];
   logic [VALUE_WIDTH-1:0]      rd_data_ff;

   logic                        rd_en;
   logic                        wr_en;
   logic [SLOT_WIDTH-1:0]       slot;
   logic [FILL_WIDTH-1:0]       cur_fill;
   logic                        out_free;
   logic                        last_bucket;
   logic                        req_accept;

   logic                        mod_start;
   logic                        mod_done;
   logic [BUCKET_WIDTH-1:0]     mod_bucket;

   logic                        emit;
   logic [KIND_WIDTH-1:0]       emit_kind;
   logic [STATUS_WIDTH-1:0]     emit_status;
   logic [VALUE_PORT_WIDTH-1:0] emit_value;
   logic                        emit_last;

   hsbi_bucket_mod u_bucket_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (value_ff),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign cur_fill       = fill_ff[bucket_ff];
   assign last_bucket    = (bucket_ff == BUCKET_WIDTH'(BUCKETS - 1));
   assign slot           = SLOT_WIDTH'(bucket_ff * BUCKET_DEPTH) + SLOT_WIDTH'(idx_ff);

   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      bucket_in   = bucket_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      fill_in     = fill_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      mod_start   = 1'b0;
      emit        = 1'b0;
      emit_kind   = KIND_STATUS;
      emit_status = STATUS_ADDED;
      emit_value  = '0;
      emit_last   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in  = VALUE_WIDTH'(req_chan.value);
               bucket_in = '0;
               idx_in    = '0;
               if (req_chan.action == ACTION_INSERT) begin
                  state_in = S_MOD;
               end else begin
                  state_in = S_DRD;
               end
            end
         end
         S_MOD: begin
            // value_ff is stable here; kick the index unit once on entry
            mod_start = (idx_ff == '0) && !mod_done;
            idx_in    = FILL_WIDTH'(1);
            if (mod_done) begin
               bucket_in = mod_bucket;
               idx_in    = '0;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            if (idx_ff < cur_fill) begin
               rd_en    = 1'b1;
               state_in = S_CHK;
            end else if (cur_fill == FILL_WIDTH'(BUCKET_DEPTH)) begin
               status_in = STATUS_FULL;
               state_in  = S_EMIT;
            end else begin
               wr_en              = 1'b1;
               fill_in[bucket_ff] = cur_fill + FILL_WIDTH'(1);
               status_in          = STATUS_ADDED;
               state_in           = S_EMIT;
            end
         end
         S_CHK: begin
            if (rd_data_ff == value_ff) begin
               status_in = STATUS_PRESENT;
               state_in  = S_EMIT;
            end else begin
               idx_in   = idx_ff + FILL_WIDTH'(1);
               state_in = S_RD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_kind   = KIND_STATUS;
               emit_status = status_ff;
               emit_value  = VALUE_PORT_WIDTH'(value_ff);
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DRD: begin
            if (cur_fill == '0) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = KIND_EMPTY;
                  emit_last = last_bucket;
                  bucket_in = bucket_ff + BUCKET_WIDTH'(1);
                  state_in  = last_bucket ? S_IDLE : S_DRD;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_DOUT;
            end
         end
         S_DOUT: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_ENTRY;
               emit_value = VALUE_PORT_WIDTH'(rd_data_ff);
               if (idx_ff == cur_fill - FILL_WIDTH'(1)) begin
                  emit_last = last_bucket;
                  idx_in    = '0;
                  bucket_in = bucket_ff + BUCKET_WIDTH'(1);
                  state_in  = last_bucket ? S_IDLE : S_DRD;
               end else begin
                  idx_in   = idx_ff + FILL_WIDTH'(1);
                  state_in = S_DRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold the result until taken, load a new one when the slot frees
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = emit_kind;
         rsp_status_in = emit_status;
         rsp_bucket_in = bucket_ff;
         rsp_value_in  = emit_value;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < BUCKETS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
      end
      value_ff      <= value_in;
      bucket_ff     <= bucket_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[slot] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[slot];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.bucket      = rsp_bucket_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.last        = rsp_last_ff;

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (mod_bucket < BUCKET_WIDTH'(BUCKETS)))
      else $error("bucket index out of range");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_STATUS)) |-> rsp_last_ff)
      else $error("insert status without last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (cur_fill <= FILL_WIDTH'(BUCKET_DEPTH)))
      else $error("bucket fill above depth");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

/* test/tb_hash_set_bucket_insert_unit.sv */
// Testbench for hash_set_bucket_insert_unit: a directed table, then random inserts
// and dumps, each response checked against an in-bench model of the bucket set or a typed row.
// Depends on hsbi_pkg and the hsbi_req_if / hsbi_rsp_if interfaces.
module tb_hash_set_bucket_insert_unit;
   import hsbi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 500;
   localparam int IDLE_PCT      = 36;
   localparam int CALM_FIRST    = 200;
   localparam int CALM_LAST     = 300;
   localparam int HOLDOFF_AT    = 350;
   localparam int HOLDOFF_LEN   = 300;
   localparam int STUCK_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]       kind;
      logic [STATUS_WIDTH-1:0]     status;
      logic [BUCKET_WIDTH-1:0]     bucket;
      logic [VALUE_PORT_WIDTH-1:0] entry_value;
      logic                        last;
   } set_rsp_type;

   typedef struct packed {
      logic                        action;
      logic [VALUE_PORT_WIDTH-1:0] value;
      logic                        typed;
      logic [STATUS_WIDTH-1:0]     status;
      logic [BUCKET_WIDTH-1:0]     bucket;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 23;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ACTION_DUMP,   16'h0000, 1'b0, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd0,    1'b1, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd0,    1'b1, STATUS_PRESENT, 4'd0},
      '{ACTION_INSERT, 16'd65535, 1'b1, STATUS_ADDED,  4'd5},
      '{ACTION_INSERT, 16'd10,   1'b1, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd20,   1'b1, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd30,   1'b1, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd40,   1'b1, STATUS_FULL,    4'd0},
      '{ACTION_INSERT, 16'd30,   1'b1, STATUS_PRESENT, 4'd0},
      '{ACTION_INSERT, 16'd65530, 1'b1, STATUS_FULL,   4'd0},
      '{ACTION_INSERT, 16'd65525, 1'b1, STATUS_ADDED,  4'd5},
      '{ACTION_INSERT, 16'd65515, 1'b1, STATUS_ADDED,  4'd5},
      '{ACTION_INSERT, 16'd65505, 1'b1, STATUS_ADDED,  4'd5},
      '{ACTION_INSERT, 16'd65495, 1'b1, STATUS_FULL,   4'd5},
      '{ACTION_INSERT, 16'd65535, 1'b1, STATUS_PRESENT, 4'd5},
      '{ACTION_DUMP,   16'hFFFF, 1'b0, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'hAAAA, 1'b1, STATUS_FULL,    4'd0},
      '{ACTION_INSERT, 16'h5555, 1'b1, STATUS_FULL,    4'd5},
      '{ACTION_INSERT, 16'd7,    1'b1, STATUS_ADDED,   4'd7},
      '{ACTION_INSERT, 16'h8001, 1'b1, STATUS_ADDED,   4'd9},
      '{ACTION_DUMP,   16'h5A5A, 1'b0, STATUS_ADDED,   4'd0},
      '{ACTION_INSERT, 16'd12,   1'b0, STATUS_ADDED,   4'd0},
      '{ACTION_DUMP,   16'h0000, 1'b0, STATUS_ADDED,   4'd0}
   };

   logic clock;
   logic reset;

   hsbi_req_if req_chan ();
   hsbi_rsp_if rsp_chan ();

   hash_set_bucket_insert_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Model of the set contents
   logic [VALUE_WIDTH-1:0] model_slots [BUCKETS][BUCKET_DEPTH];
   int unsigned            model_fill  [BUCKETS];
   logic [VALUE_PORT_WIDTH-1:0] held_values [$];

   set_rsp_type expected_rsps [$];
   int          sent_count;
   int          mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void predict_set_request(input logic act,
                                               input logic [VALUE_PORT_WIDTH-1:0] raw);
      logic [VALUE_WIDTH-1:0]  v;
      logic [STATUS_WIDTH-1:0] st;
      int unsigned             b;
      int unsigned             n;
      set_rsp_type             r;
      v = raw[VALUE_WIDTH-1:0];
      if (act == ACTION_INSERT) begin
         b  = v % BUCKETS;
         n  = model_fill[b];
         st = STATUS_ADDED;
         for (int j = 0; j < n; j++) begin
            if (model_slots[b][j] == v) st = STATUS_PRESENT;
         end
         if (st == STATUS_ADDED) begin
            if (n >= BUCKET_DEPTH) begin
               st = STATUS_FULL;
            end else begin
               model_slots[b][n] = v;
               model_fill[b]     = n + 1;
               held_values.push_back(VALUE_PORT_WIDTH'(v));
            end
         end
         r = '{KIND_STATUS, st, BUCKET_WIDTH'(b), VALUE_PORT_WIDTH'(v), 1'b1};
         expected_rsps.push_back(r);
      end else begin
         for (int bb = 0; bb < BUCKETS; bb++) begin
            if (model_fill[bb] == 0) begin
               r = '{KIND_EMPTY, STATUS_ADDED, BUCKET_WIDTH'(bb), '0, 1'b0};
               expected_rsps.push_back(r);
            end else begin
               for (int j = 0; j < model_fill[bb]; j++) begin
                  r = '{KIND_ENTRY, STATUS_ADDED, BUCKET_WIDTH'(bb),
                        VALUE_PORT_WIDTH'(model_slots[bb][j]), 1'b0};
                  expected_rsps.push_back(r);
               end
            end
         end
         // mark the final dump response
         r = expected_rsps.pop_back();
         r.last = 1'b1;
         expected_rsps.push_back(r);
      end
   endfunction

   task automatic offer_request(input logic act, input logic [VALUE_PORT_WIDTH-1:0] val,
                                input logic typed, input logic [STATUS_WIDTH-1:0] st,
                                input logic [BUCKET_WIDTH-1:0] bkt);
      set_rsp_type typed_rsp;
      while ((sent_count < CALM_FIRST || sent_count >= CALM_LAST)
             && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.value  <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_set_request(act, val);
      if (typed) begin
         // replace the model's answer with the one written in the table
         void'(expected_rsps.pop_back());
         typed_rsp = '{KIND_STATUS, st, bkt, val, 1'b1};
         expected_rsps.push_back(typed_rsp);
      end
      sent_count++;
   endtask

   initial begin : stimulus
      directed_row_type            row;
      logic                        act;
      logic [VALUE_PORT_WIDTH-1:0] val;
      int unsigned                 pick;
      for (int b = 0; b < BUCKETS; b++) model_fill[b] = 0;
      sent_count      = 0;
      mismatch_count  = 0;
      req_chan.valid  = 1'b0;
      req_chan.action = ACTION_INSERT;
      req_chan.value  = '0;
      do @(posedge clock); while (reset);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         offer_request(row.action, row.value, row.typed, row.status, row.bucket);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         act  = ACTION_INSERT;
         val  = VALUE_PORT_WIDTH'($urandom);
         if (pick < 10) begin
            act = ACTION_DUMP;
         end else if (pick < 40 && held_values.size() != 0) begin
            val = held_values[$urandom_range(0, held_values.size() - 1)];
         end else if (pick < 60) begin
            val = VALUE_PORT_WIDTH'($urandom_range(0, 99));
         end
         offer_request(act, val, 1'b0, STATUS_ADDED, '0);
      end
      req_chan.valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Response side: check accepted responses, then pick ready for the next cycle
   initial begin : response_check
      set_rsp_type got;
      set_rsp_type want;
      int unsigned holdoff_left;
      bit          holdoff_done;
      holdoff_left  = 0;
      holdoff_done  = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.kind, rsp_chan.status, rsp_chan.bucket,
                    rsp_chan.entry_value, rsp_chan.last};
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected response: kind %0d status %0d bucket %0d value %0d last %0d",
                           got.kind, got.status, got.bucket, got.entry_value, got.last);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"response mismatch: expected kind %0d status %0d bucket %0d ",
                               "value %0d last %0d, got kind %0d status %0d bucket %0d ",
                               "value %0d last %0d"},
                              want.kind, want.status, want.bucket, want.entry_value, want.last,
                              got.kind, got.status, got.bucket, got.entry_value, got.last);
               end
            end
         end
         // hold off once for a long stretch so the unit backs up its request side
         if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else if (sent_count >= CALM_FIRST && sent_count < CALM_LAST) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
